>>> hdl/dsdf_pkg.sv
// shared types, constants and segment table of the decimal display framer
`default_nettype none
package dsdf_pkg;

  // driver command bytes
  localparam logic [7:0] CmdData    = 8'h40;
  localparam logic [7:0] CmdAddr    = 8'hC0;
  localparam logic [7:0] CmdDisplay = 8'h8F;

  // minus pattern (segment g only) and blank pattern
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegBlank = 8'h00;

  // widths of the number path
  localparam int unsigned ValueW = 15;
  localparam int unsigned MagW   = 14;
  localparam int unsigned ProdW  = 28;
  localparam int unsigned Q1000W = 4;
  localparam int unsigned Q100W  = 7;
  localparam int unsigned Q10W   = 10;

  localparam logic [MagW-1:0] MaxMag = 14'd9999;

  // reciprocal multipliers, exact for every magnitude up to 9999
  localparam logic [MagW-1:0] Recip1000 = 14'd8389;
  localparam int unsigned     Shift1000 = 23;
  localparam logic [MagW-1:0] Recip100  = 14'd10486;
  localparam int unsigned     Shift100  = 20;
  localparam logic [MagW-1:0] Recip10   = 14'd13108;
  localparam int unsigned     Shift10   = 17;

  typedef logic [7:0] seg_t;

  // four segment bytes, most significant position first
  typedef struct packed {
    seg_t dig3;
    seg_t dig2;
    seg_t dig1;
    seg_t dig0;
  } seg_word_t;

  // decimal digit to segment byte, bit 0 is segment a
  function automatic seg_t seg_of(input logic [3:0] digit);
    seg_t seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dsdf_in_if.sv
// number channel: display mode and value
`default_nettype none
interface dsdf_in_if;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [14:0]      value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

>>> hdl/dsdf_out_if.sv
// framed byte channel toward the two-wire driver
`default_nettype none
interface dsdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;

  modport source (output valid, output wire_byte, output start_before,
                  output stop_after, output last, input ready);
  modport sink   (input valid, input wire_byte, input start_before,
                  input stop_after, input last, output ready);
endinterface
`default_nettype wire

>>> hdl/dsdf_digits.sv
// number to four segment bytes: clamp, reciprocal divide, digit lookup
`default_nettype none
module dsdf_digits (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  dsdf_in_if.sink             in_i,
  output logic                word_valid_o,
  input  wire                 word_ready_i,
  output dsdf_pkg::seg_word_t word_o
);

  // stage valids
  logic v_in_q, v_mag_q, v_quo_q, v_seg_q;
  logic rdy_in, rdy_mag, rdy_quo, rdy_seg;

  // input register
  logic                         kind_q;
  logic signed [14:0]           value_q;

  // magnitude stage
  logic [dsdf_pkg::MagW-1:0]    mag_d, mag_q;
  logic                         minus_d, minus_q;
  logic [dsdf_pkg::ValueW-1:0]  raw;
  logic [dsdf_pkg::ValueW-1:0]  abs_val;
  logic                         neg;

  // quotient stage
  logic [dsdf_pkg::ProdW-1:0]   p1000, p100, p10;
  logic [dsdf_pkg::Q1000W-1:0]  q1000_d, q1000_q;
  logic [dsdf_pkg::Q100W-1:0]   q100_d, q100_q;
  logic [dsdf_pkg::Q10W-1:0]    q10_d, q10_q;
  logic [dsdf_pkg::MagW-1:0]    mag2_q;
  logic                         minus2_q;

  // segment stage
  logic [3:0]                   d3, d2, d1, d0;
  dsdf_pkg::seg_word_t          seg_d, seg_q;

  // stall chain, a stage moves when it is empty or its successor moves
  assign rdy_seg   = !v_seg_q || word_ready_i;
  assign rdy_quo   = !v_quo_q || rdy_seg;
  assign rdy_mag   = !v_mag_q || rdy_quo;
  assign rdy_in    = !v_in_q  || rdy_mag;
  assign in_i.ready = rdy_in;

  // sign handling and saturation
  always_comb begin
    raw     = $unsigned(value_q);
    neg     = value_q[dsdf_pkg::ValueW-1];
    abs_val = neg ? (15'd0 - raw) : raw;
    minus_d = neg && kind_q;
    if (neg && !kind_q) begin
      mag_d = '0;
    end else if (abs_val > 15'(dsdf_pkg::MaxMag)) begin
      mag_d = dsdf_pkg::MaxMag;
    end else begin
      mag_d = abs_val[dsdf_pkg::MagW-1:0];
    end
  end

  // quotients by 1000, 100 and 10 through reciprocal multiplies
  always_comb begin
    p1000   = 28'(mag_q) * 28'(dsdf_pkg::Recip1000);
    p100    = 28'(mag_q) * 28'(dsdf_pkg::Recip100);
    p10     = 28'(mag_q) * 28'(dsdf_pkg::Recip10);
    q1000_d = p1000[dsdf_pkg::Shift1000 + dsdf_pkg::Q1000W - 1 : dsdf_pkg::Shift1000];
    q100_d  = p100[dsdf_pkg::Shift100 + dsdf_pkg::Q100W - 1 : dsdf_pkg::Shift100];
    q10_d   = p10[dsdf_pkg::Shift10 + dsdf_pkg::Q10W - 1 : dsdf_pkg::Shift10];
  end

  // digits from neighboring quotients, lookup and leading blanks
  always_comb begin
    d3 = q1000_q;
    d2 = 4'(q100_q - 7'({3'b000, q1000_q} * 7'd10));
    d1 = 4'(q10_q - 10'({3'b000, q100_q} * 10'd10));
    d0 = 4'(mag2_q - 14'({4'b0000, q10_q} * 14'd10));
    seg_d.dig0 = dsdf_pkg::seg_of(d0);
    seg_d.dig1 = (q10_q != '0)   ? dsdf_pkg::seg_of(d1) : dsdf_pkg::SegBlank;
    seg_d.dig2 = (q100_q != '0)  ? dsdf_pkg::seg_of(d2) : dsdf_pkg::SegBlank;
    seg_d.dig3 = (q1000_q != '0) ? dsdf_pkg::seg_of(d3) : dsdf_pkg::SegBlank;
    if (minus2_q) begin
      seg_d.dig3 = dsdf_pkg::SegMinus;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_mag_q <= 1'b0;
      v_quo_q <= 1'b0;
      v_seg_q <= 1'b0;
    end else begin
      if (rdy_in)  v_in_q  <= in_i.valid;
      if (rdy_mag) v_mag_q <= v_in_q;
      if (rdy_quo) v_quo_q <= v_mag_q;
      if (rdy_seg) v_seg_q <= v_quo_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy_in && in_i.valid) begin
      kind_q  <= in_i.kind;
      value_q <= in_i.value;
    end
    if (rdy_mag && v_in_q) begin
      mag_q   <= mag_d;
      minus_q <= minus_d;
    end
    if (rdy_quo && v_mag_q) begin
      q1000_q  <= q1000_d;
      q100_q   <= q100_d;
      q10_q    <= q10_d;
      mag2_q   <= mag_q;
      minus2_q <= minus_q;
    end
    if (rdy_seg && v_quo_q) begin
      seg_q <= seg_d;
    end
  end

  assign word_valid_o = v_seg_q;
  assign word_o       = seg_q;

endmodule
`default_nettype wire

>>> hdl/dsdf_framer.sv
// byte sequencer: seven framed bytes per segment word
`default_nettype none
module dsdf_framer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 word_valid_i,
  output logic                word_ready_o,
  input  dsdf_pkg::seg_word_t word_i,
  dsdf_out_if.source          out_o
);

  typedef enum logic [2:0] {
    PosData,
    PosAddr,
    PosDig3,
    PosDig2,
    PosDig1,
    PosDig0,
    PosDisp
  } pos_e;

  logic                active_d, active_q;
  pos_e                idx_d, idx_q;
  logic                ov_d, ov_q;
  dsdf_pkg::seg_word_t sw_d, sw_q;
  logic [7:0]          byte_d, byte_q;
  logic                start_d, start_q;
  logic                stop_d, stop_q;
  logic                last_d, last_q;
  logic                advance;

  // output register takes a byte when empty or when its transfer completes
  assign advance      = !ov_q || out_o.ready;
  assign word_ready_o = !active_q || (advance && idx_q == PosDisp);

  // next byte and sequence position
  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    ov_d     = ov_q;
    sw_d     = sw_q;
    byte_d   = byte_q;
    start_d  = start_q;
    stop_d   = stop_q;
    last_d   = last_q;
    if (advance) begin
      ov_d = active_q;
      if (active_q) begin
        start_d = 1'b0;
        stop_d  = 1'b0;
        last_d  = 1'b0;
        unique case (idx_q)
          PosData: begin
            byte_d  = dsdf_pkg::CmdData;
            start_d = 1'b1;
            stop_d  = 1'b1;
            idx_d   = PosAddr;
          end
          PosAddr: begin
            byte_d  = dsdf_pkg::CmdAddr;
            start_d = 1'b1;
            idx_d   = PosDig3;
          end
          PosDig3: begin
            byte_d = sw_q.dig3;
            idx_d  = PosDig2;
          end
          PosDig2: begin
            byte_d = sw_q.dig2;
            idx_d  = PosDig1;
          end
          PosDig1: begin
            byte_d = sw_q.dig1;
            idx_d  = PosDig0;
          end
          PosDig0: begin
            byte_d = sw_q.dig0;
            stop_d = 1'b1;
            idx_d  = PosDisp;
          end
          PosDisp: begin
            byte_d   = dsdf_pkg::CmdDisplay;
            start_d  = 1'b1;
            stop_d   = 1'b1;
            last_d   = 1'b1;
            active_d = 1'b0;
            idx_d    = PosData;
          end
          default: begin
            ov_d     = 1'b0;
            active_d = 1'b0;
            idx_d    = PosData;
          end
        endcase
      end
    end
    // a new word loads behind the closing byte of the previous one
    if (word_valid_i && word_ready_o) begin
      sw_d     = word_i;
      idx_d    = PosData;
      active_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= PosData;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      ov_q     <= ov_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    sw_q    <= sw_d;
    byte_q  <= byte_d;
    start_q <= start_d;
    stop_q  <= stop_d;
    last_q  <= last_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.wire_byte    = byte_q;
  assign out_o.start_before = start_q;
  assign out_o.stop_after   = stop_q;
  assign out_o.last         = last_q;

  // closing byte is always the display-on command
  a_last_is_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && last_q |-> byte_q == dsdf_pkg::CmdDisplay)
    else $error("last flag on a byte other than display-on");

  // a loaded word starts at the data command
  a_word_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_i && word_ready_o |=> active_q && idx_q == PosData)
    else $error("word transfer did not restart the sequence");

  // a stalled sequence does not move on
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_o.ready && active_q |=> $stable(idx_q) && active_q)
    else $error("sequence advanced while output stalled");

endmodule
`default_nettype wire

>>> hdl/decimal_segment_display_framer_core.sv
// top level of the four-digit decimal display framer
//
// in_i takes one number per transfer: kind selects unsigned (0) or signed
// display (1), value is a 15-bit two's complement number. Magnitudes above
// 9999 saturate, negatives clamp to zero in unsigned mode, and in signed mode
// a negative number shows a minus in the top position.
// out_o delivers seven framed bytes per number, in order: data command,
// address command, four segment bytes (most significant first), display-on
// command. start_before, stop_after and last mark the two-wire framing.
// A number passes the input, magnitude, quotient and segment registers and
// the framer's word register before its first byte is valid in the single
// byte output register of the framer, which paces the output; the four-stage
// digit pipeline in front of it buffers further numbers while bytes go out.
// Reset clears all valid flags; nothing is emitted until a number arrives.
// When out_o stalls, the current byte holds and the pipeline fills, after
// which in_i.ready drops until bytes move again.
`default_nettype none
module decimal_segment_display_framer_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  dsdf_in_if.sink    in_i,
  dsdf_out_if.source out_o
);

  logic                word_valid;
  logic                word_ready;
  dsdf_pkg::seg_word_t word;

  // number to segment bytes
  dsdf_digits u_digits (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  // segment bytes to framed byte stream
  dsdf_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_ready_o (word_ready),
    .word_i       (word),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

>>> tb/decimal_segment_display_framer_core_tb.sv
// self-checking testbench of the four-digit decimal display framer
`timescale 1ns / 100ps
module decimal_segment_display_framer_core_tb;

  // display modes
  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomPerPhase = 24;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned NumDirected = 25;

  // one framed byte as it leaves the block
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } framed_byte_t;

  // one directed number, with its segment bytes typed in where obvious
  typedef struct packed {
    logic                kind;
    logic [14:0]         value;
    logic                typed;
    dsdf_pkg::seg_word_t segs;
  } number_row_t;

  localparam dsdf_pkg::seg_t Seg0 = 8'h3F;
  localparam dsdf_pkg::seg_t Seg1 = 8'h06;
  localparam dsdf_pkg::seg_t Seg9 = 8'h6F;

  localparam dsdf_pkg::seg_word_t ShowZero =
    '{dsdf_pkg::SegBlank, dsdf_pkg::SegBlank, dsdf_pkg::SegBlank, Seg0};
  localparam dsdf_pkg::seg_word_t ShowMax  = '{Seg9, Seg9, Seg9, Seg9};
  localparam dsdf_pkg::seg_word_t ShowMin  = '{dsdf_pkg::SegMinus, Seg9, Seg9, Seg9};
  localparam dsdf_pkg::seg_word_t NoSegs   = '0;

  localparam number_row_t DirectedRows [NumDirected] = '{
    '{KindUnsigned, 15'sd0,      1'b1, ShowZero},
    '{KindUnsigned, 15'sd9999,   1'b1, ShowMax},
    '{KindUnsigned, 15'sd16383,  1'b1, ShowMax},
    '{KindUnsigned, 15'sd10000,  1'b1, ShowMax},
    '{KindUnsigned, -15'sd1,     1'b1, ShowZero},
    '{KindUnsigned, -15'sd16384, 1'b1, ShowZero},
    '{KindSigned,   15'sd0,      1'b1, ShowZero},
    '{KindSigned,   -15'sd1,     1'b1,
      '{dsdf_pkg::SegMinus, dsdf_pkg::SegBlank, dsdf_pkg::SegBlank, Seg1}},
    '{KindSigned,   -15'sd9999,  1'b1, ShowMin},
    '{KindSigned,   -15'sd10000, 1'b1, ShowMin},
    '{KindSigned,   -15'sd16384, 1'b1, ShowMin},
    '{KindSigned,   15'sd16383,  1'b1, ShowMax},
    '{KindSigned,   -15'sd1234,  1'b1, '{dsdf_pkg::SegMinus, 8'h5B, 8'h4F, 8'h66}},
    '{KindUnsigned, 15'sd1234,   1'b1, '{Seg1, 8'h5B, 8'h4F, 8'h66}},
    '{KindUnsigned, 15'sd9,      1'b0, NoSegs},
    '{KindUnsigned, 15'sd10,     1'b0, NoSegs},
    '{KindUnsigned, 15'sd99,     1'b0, NoSegs},
    '{KindUnsigned, 15'sd100,    1'b0, NoSegs},
    '{KindUnsigned, 15'sd999,    1'b0, NoSegs},
    '{KindUnsigned, 15'sd1000,   1'b0, NoSegs},
    '{KindUnsigned, 15'sd6789,   1'b0, NoSegs},
    '{KindSigned,   -15'sd12,    1'b0, NoSegs},
    '{KindSigned,   15'sd5050,   1'b0, NoSegs},
    '{KindSigned,   -15'sd908,   1'b0, NoSegs},
    '{KindUnsigned, 15'sd7,      1'b0, NoSegs}
  };

  // digit to segment byte, bit 0 is segment a
  localparam dsdf_pkg::seg_t DigitSegs [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dsdf_in_if  num_ch ();
  dsdf_out_if byte_ch ();

  decimal_segment_display_framer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (byte_ch)
  );

  // side-band of the number being offered: typed-in segment bytes
  logic                item_typed;
  dsdf_pkg::seg_word_t item_segs;

  framed_byte_t expected_bytes [$];
  int unsigned  failures = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // segment bytes that a number and mode should light up
  function automatic dsdf_pkg::seg_word_t predict_segments(
    input logic kind, input logic signed [14:0] value);
    int                  mag;
    logic                minus;
    dsdf_pkg::seg_word_t segs;
    minus = 1'b0;
    if (value < 0) begin
      if (kind == KindSigned) begin
        mag   = -int'(value);
        minus = 1'b1;
      end else begin
        mag = 0;
      end
    end else begin
      mag = int'(value);
    end
    if (mag > 9999) mag = 9999;
    segs.dig0 = DigitSegs[mag % 10];
    segs.dig1 = (mag >= 10)   ? DigitSegs[(mag / 10) % 10]   : dsdf_pkg::SegBlank;
    segs.dig2 = (mag >= 100)  ? DigitSegs[(mag / 100) % 10]  : dsdf_pkg::SegBlank;
    segs.dig3 = (mag >= 1000) ? DigitSegs[(mag / 1000) % 10] : dsdf_pkg::SegBlank;
    if (minus) segs.dig3 = dsdf_pkg::SegMinus;
    return segs;
  endfunction

  // seven bytes of one display update
  task automatic queue_update(input dsdf_pkg::seg_word_t segs);
    expected_bytes.push_back('{dsdf_pkg::CmdData,    1'b1, 1'b1, 1'b0});
    expected_bytes.push_back('{dsdf_pkg::CmdAddr,    1'b1, 1'b0, 1'b0});
    expected_bytes.push_back('{segs.dig3,            1'b0, 1'b0, 1'b0});
    expected_bytes.push_back('{segs.dig2,            1'b0, 1'b0, 1'b0});
    expected_bytes.push_back('{segs.dig1,            1'b0, 1'b0, 1'b0});
    expected_bytes.push_back('{segs.dig0,            1'b0, 1'b1, 1'b0});
    expected_bytes.push_back('{dsdf_pkg::CmdDisplay, 1'b1, 1'b1, 1'b1});
  endtask

  // random number, weighted toward the interesting corners
  function automatic logic signed [14:0] random_value();
    logic signed [14:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = 15'($signed($urandom_range(19998)) - 9999);
      5, 6:          v = 15'($urandom);
      7:             v = 15'($urandom_range(99));
      8:             v = 15'($urandom_range(10010, 9990));
      default:       v = $urandom_range(1) ? 15'sd16383 : -15'sd16384;
    endcase
    if ($urandom_range(3) == 0) v = -v;
    return v;
  endfunction

  // offer one number at a falling edge and hold it until its transfer
  task automatic send_number(input logic kind, input logic signed [14:0] value,
                             input logic typed, input dsdf_pkg::seg_word_t segs);
    while ($urandom_range(99) < src_idle_pct) begin
      num_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    num_ch.valid <= 1'b1;
    num_ch.kind  <= kind;
    num_ch.value <= value;
    item_typed   <= typed;
    item_segs    <= segs;
    do @(posedge clk_i); while (!num_ch.ready);
    @(negedge clk_i);
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    byte_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // expectations on number transfers, checks on byte transfers
  always @(posedge clk_i) begin
    framed_byte_t exp_b;
    if (rst_ni) begin
      if (num_ch.valid && num_ch.ready) begin
        if (item_typed) queue_update(item_segs);
        else queue_update(predict_segments(num_ch.kind, num_ch.value));
      end
      if (byte_ch.valid && byte_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %h", byte_ch.wire_byte);
          failures++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (byte_ch.wire_byte !== exp_b.wire_byte) begin
            $error("wire_byte: expected %h, actual %h", exp_b.wire_byte,
                   byte_ch.wire_byte);
            failures++;
          end
          if (byte_ch.start_before !== exp_b.start_before) begin
            $error("start_before: expected %b, actual %b", exp_b.start_before,
                   byte_ch.start_before);
            failures++;
          end
          if (byte_ch.stop_after !== exp_b.stop_after) begin
            $error("stop_after: expected %b, actual %b", exp_b.stop_after,
                   byte_ch.stop_after);
            failures++;
          end
          if (byte_ch.last !== exp_b.last) begin
            $error("last: expected %b, actual %b", exp_b.last, byte_ch.last);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((num_ch.valid && num_ch.ready) || (byte_ch.valid && byte_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL decimal_segment_display_framer_core");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    rst_ni        = 1'b0;
    num_ch.valid  = 1'b0;
    num_ch.kind   = KindUnsigned;
    num_ch.value  = '0;
    byte_ch.ready = 1'b0;
    item_typed    = 1'b0;
    item_segs     = NoSegs;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, no idling
    for (n = 0; n < NumDirected; n++) begin
      send_number(DirectedRows[n].kind, $signed(DirectedRows[n].value),
                  DirectedRows[n].typed, DirectedRows[n].segs);
    end

    // random numbers under each idling pattern
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      for (n = 0; n < RandomPerPhase; n++) begin
        send_number(1'($urandom_range(1)), random_value(), 1'b0, NoSegs);
      end
      num_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end

    // drain
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_bytes.size() != 0) failures++;
    if (failures == 0) begin
      $display("PASS decimal_segment_display_framer_core");
    end else begin
      $display("FAIL decimal_segment_display_framer_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dsdf_pkg.sv
hdl/dsdf_in_if.sv
hdl/dsdf_out_if.sv
hdl/dsdf_digits.sv
hdl/dsdf_framer.sv
hdl/decimal_segment_display_framer_core.sv
tb/decimal_segment_display_framer_core_tb.sv
